// File: src/ate_pkg.sv
// Shared types and constants of the ANSI text console engine.
`default_nettype none
package ate_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 128;

  localparam logic [6:0] ROWS_LIM = 7'((MAX_ROWS < 64) ? MAX_ROWS : 64);
  localparam logic [7:0] COLS_LIM = 8'((MAX_COLS < 128) ? MAX_COLS : 128);

  localparam logic [6:0] ROWS_RESET = 7'd25;
  localparam logic [7:0] COLS_RESET = 8'd80;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_CURSOR = 3'd1;
  localparam logic [2:0] CMD_ATTR   = 3'd2;
  localparam logic [2:0] CMD_COPY   = 3'd3;
  localparam logic [2:0] CMD_ERASE  = 3'd4;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] target_row;
    logic [6:0] target_col;
    logic [7:0] char_code;
    logic [7:0] attribute_value;
    logic [5:0] source_row;
    logic [6:0] row_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       count;
    cmd_t [2:0]       slot;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// File: src/ate_ifs.sv
// Channel interfaces for input bytes and video commands.
`default_nettype none
interface ate_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface ate_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [5:0] target_row;
  logic [6:0] target_col;
  logic [7:0] char_code;
  logic [7:0] attribute_value;
  logic [5:0] source_row;
  logic [6:0] row_count;
  logic       last_command;
  modport source (output valid, output command, output target_row, output target_col,
                  output char_code, output attribute_value, output source_row,
                  output row_count, output last_command, input ready);
  modport sink (input valid, input command, input target_row, input target_col,
                input char_code, input attribute_value, input source_row,
                input row_count, input last_command, output ready);
endinterface
`default_nettype wire

// File: src/ate_front.sv
// Front end: byte parser, cursor and attribute state, and command job builder.
`default_nettype none
module ate_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ate_char_if.sink           chars,
  input  wire logic [6:0]    screen_rows,
  input  wire logic [7:0]    screen_cols,
  input  wire ate_pkg::q_stat_t q_stat,
  output      logic          push,
  output      ate_pkg::job_t push_job
);
  import ate_pkg::*;

  localparam logic [7:0] CH_ESC  = 8'd27;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_UP   = 8'h41;
  localparam logic [7:0] CH_DOWN = 8'h42;
  localparam logic [7:0] CH_RGHT = 8'h43;
  localparam logic [7:0] CH_LEFT = 8'h44;
  localparam logic [7:0] CH_HOME = 8'h48;
  localparam logic [7:0] CH_POSF = 8'h66;
  localparam logic [7:0] CH_CLR  = 8'h4A;
  localparam logic [7:0] CH_ATTR = 8'h6D;
  localparam logic [7:0] CH_SAVE = 8'h73;
  localparam logic [7:0] CH_REST = 8'h75;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [3:0] P_BRACKET = 4'd2;
  localparam logic [3:0] P_FINAL1  = 4'd3;
  localparam logic [3:0] P_ARG     = 4'd4;
  localparam logic [3:0] P_FINAL2  = 4'd6;

  localparam logic [7:0] ATTR_DEFAULT = 8'h0F;
  localparam logic [7:0] ATTR_BLINK   = 8'h80;

  function automatic logic [2:0] colour_map(input logic [2:0] i);
    logic [2:0] r;
    case (i)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic cmd_t mk(input logic [2:0] c, input logic [5:0] r, input logic [6:0] col,
                              input logic [7:0] ch, input logic [7:0] at,
                              input logic [5:0] s, input logic [6:0] cnt);
    cmd_t m;
    m.command = c;
    m.target_row = r;
    m.target_col = col;
    m.char_code = ch;
    m.attribute_value = at;
    m.source_row = s;
    m.row_count = cnt;
    return m;
  endfunction

  function automatic logic [6:0] times10_plus(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] t;
    t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {7'd0, d};
    return t[6:0];
  endfunction

  logic [5:0] cursor_row, cursor_row_next;
  logic [6:0] cursor_col, cursor_col_next;
  logic [7:0] current_attribute, current_attribute_next;
  logic [2:0] escape_phase, escape_phase_next;
  logic [2:0] digit_count, digit_count_next;
  logic [6:0] first_argument, first_argument_next;
  logic [6:0] second_argument, second_argument_next;
  logic [5:0] stash_row, stash_row_next;
  logic [6:0] stash_col, stash_col_next;

  logic [6:0] rows_eff;
  logic [7:0] cols_eff;
  logic [5:0] rows_m1;
  logic [6:0] cols_m1;
  logic [6:0] nr;
  logic       wrap_scroll;
  logic [5:0] nr_row;
  logic [7:0] c;
  logic       is_digit;
  logic [3:0] dig;
  logic [3:0] p;
  logic [7:0] v8;
  logic [7:0] colp;
  logic [6:0] a30;
  logic [6:0] a40;
  logic [1:0] n;
  job_t       job;
  logic       accept;

  assign c = chars.char_in;
  assign chars.ready = !q_stat.full;
  assign accept = chars.valid && chars.ready;

  always_comb begin
    rows_eff = screen_rows;
    if (screen_rows == 7'd0) rows_eff = 7'd1;
    else if (screen_rows > ROWS_LIM) rows_eff = ROWS_LIM;
    cols_eff = screen_cols;
    if (screen_cols == 8'd0) cols_eff = 8'd1;
    else if (screen_cols > COLS_LIM) cols_eff = COLS_LIM;
  end

  assign rows_m1 = 6'(rows_eff - 7'd1);
  assign cols_m1 = 7'(cols_eff - 8'd1);
  assign nr = {1'b0, cursor_row} + 7'd1;
  assign wrap_scroll = (nr >= rows_eff);
  assign nr_row = wrap_scroll ? rows_m1 : nr[5:0];
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig = 4'(c - CH_ZERO);
  assign p = {1'b0, escape_phase} + 4'd1;
  assign colp = {1'b0, cursor_col} + 8'd1;
  assign a30 = first_argument - 7'd30;
  assign a40 = first_argument - 7'd40;

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    current_attribute_next = current_attribute;
    escape_phase_next = escape_phase;
    digit_count_next = digit_count;
    first_argument_next = first_argument;
    second_argument_next = second_argument;
    stash_row_next = stash_row;
    stash_col_next = stash_col;
    job = '0;
    n = 2'd0;
    v8 = 8'd0;

    if (c == CH_ESC) begin
      escape_phase_next = PH_ESC;
      digit_count_next = 3'd0;
    end else if (escape_phase != PH_IDLE) begin
      if (is_digit) begin
        digit_count_next = digit_count + 3'd1;
        case (digit_count)
          3'd0: begin
            first_argument_next = {3'd0, dig};
            escape_phase_next = p[2:0];
          end
          3'd1: first_argument_next = times10_plus(first_argument, dig);
          3'd2: begin
            second_argument_next = {3'd0, dig};
            escape_phase_next = p[2:0];
          end
          3'd3: second_argument_next = times10_plus(second_argument, dig);
          default: begin
            escape_phase_next = PH_IDLE;
            digit_count_next = 3'd0;
          end
        endcase
      end else begin
        escape_phase_next = p[2:0];
        case (p)
          P_BRACKET: begin
            if (c != CH_LBR) begin
              escape_phase_next = PH_IDLE;
              digit_count_next = 3'd0;
            end
          end
          P_FINAL1: begin
            if (c == CH_SAVE) begin
              stash_row_next = cursor_row;
              stash_col_next = cursor_col;
            end else if (c == CH_REST) begin
              cursor_row_next = stash_row;
              cursor_col_next = stash_col;
              job.slot[n] = mk(CMD_CURSOR, stash_row, stash_col, '0, '0, '0, '0);
              n = n + 2'd1;
            end
            escape_phase_next = PH_IDLE;
            digit_count_next = 3'd0;
          end
          P_ARG: begin
            if (c == CH_SEMI) begin
              if (digit_count == 3'd1) digit_count_next = 3'd2;
            end else begin
              escape_phase_next = PH_IDLE;
              digit_count_next = 3'd0;
              if (c == CH_UP) begin
                cursor_row_next = ({1'b0, cursor_row} >= first_argument) ?
                                  6'({1'b0, cursor_row} - first_argument) : 6'd0;
                job.slot[n] = mk(CMD_CURSOR, cursor_row_next, cursor_col, '0, '0, '0, '0);
                n = n + 2'd1;
              end else if (c == CH_DOWN) begin
                v8 = {2'b00, cursor_row} + {1'b0, first_argument};
                cursor_row_next = (v8 >= {1'b0, rows_eff}) ? rows_m1 : v8[5:0];
                job.slot[n] = mk(CMD_CURSOR, cursor_row_next, cursor_col, '0, '0, '0, '0);
                n = n + 2'd1;
              end else if (c == CH_RGHT) begin
                v8 = {1'b0, cursor_col} + {1'b0, first_argument};
                cursor_col_next = (v8 >= cols_eff) ? cols_m1 : v8[6:0];
                job.slot[n] = mk(CMD_CURSOR, cursor_row, cursor_col_next, '0, '0, '0, '0);
                n = n + 2'd1;
              end else if (c == CH_LEFT) begin
                cursor_col_next = (cursor_col >= first_argument) ?
                                  (cursor_col - first_argument) : 7'd0;
                job.slot[n] = mk(CMD_CURSOR, cursor_row, cursor_col_next, '0, '0, '0, '0);
                n = n + 2'd1;
              end else if (c == CH_CLR) begin
                if (first_argument == 7'd2) begin
                  job.slot[n] = mk(CMD_ERASE, 6'd0, '0, '0, '0, '0, rows_eff);
                  n = n + 2'd1;
                  cursor_row_next = 6'd0;
                  cursor_col_next = 7'd0;
                  job.slot[n] = mk(CMD_CURSOR, 6'd0, 7'd0, '0, '0, '0, '0);
                  n = n + 2'd1;
                end
              end else if (c == CH_ATTR) begin
                if (first_argument == 7'd0 || first_argument == 7'd1) begin
                  current_attribute_next = ATTR_DEFAULT;
                end else if (first_argument == 7'd5) begin
                  current_attribute_next = current_attribute | ATTR_BLINK;
                end else if (first_argument >= 7'd30 && first_argument <= 7'd37) begin
                  current_attribute_next = {current_attribute[7:4], 1'b0,
                                            colour_map(a30[2:0])};
                end else if (first_argument >= 7'd40 && first_argument <= 7'd47) begin
                  current_attribute_next = {1'b0, colour_map(a40[2:0]),
                                            current_attribute[3:0]};
                end
                job.slot[n] = mk(CMD_ATTR, '0, '0, '0, current_attribute_next, '0, '0);
                n = n + 2'd1;
              end
            end
          end
          P_FINAL2: begin
            if (c == CH_HOME || c == CH_POSF) begin
              cursor_row_next = (first_argument >= rows_eff) ? rows_m1 : first_argument[5:0];
              cursor_col_next = ({1'b0, second_argument} >= cols_eff) ? cols_m1 :
                                second_argument;
              job.slot[n] = mk(CMD_CURSOR, cursor_row_next, cursor_col_next,
                               '0, '0, '0, '0);
              n = n + 2'd1;
            end
            escape_phase_next = PH_IDLE;
            digit_count_next = 3'd0;
          end
          default: begin
            escape_phase_next = PH_IDLE;
            digit_count_next = 3'd0;
          end
        endcase
      end
    end else if (c == CH_LF) begin
      cursor_col_next = 7'd0;
      cursor_row_next = nr_row;
      if (wrap_scroll) begin
        job.slot[n] = mk(CMD_COPY, 6'd0, '0, '0, '0, 6'd1, 7'(rows_m1));
        n = n + 2'd1;
        job.slot[n] = mk(CMD_ERASE, rows_m1, '0, '0, '0, '0, 7'd1);
        n = n + 2'd1;
      end
    end else if (c == CH_CR) begin
      cursor_col_next = 7'd0;
    end else if (c == CH_BS) begin
      if (cursor_col != 7'd0) cursor_col_next = cursor_col - 7'd1;
    end else begin
      job.slot[n] = mk(CMD_PUT, cursor_row, cursor_col, c, '0, '0, '0);
      n = n + 2'd1;
      if (colp >= cols_eff) begin
        cursor_col_next = 7'd0;
        cursor_row_next = nr_row;
        if (wrap_scroll) begin
          job.slot[n] = mk(CMD_COPY, 6'd0, '0, '0, '0, 6'd1, 7'(rows_m1));
          n = n + 2'd1;
          job.slot[n] = mk(CMD_ERASE, rows_m1, '0, '0, '0, '0, 7'd1);
          n = n + 2'd1;
        end
      end else begin
        cursor_col_next = colp[6:0];
      end
    end
    job.count = n;
  end

  assign push = accept && (job.count != 2'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= 6'd0;
      cursor_col <= 7'd0;
      current_attribute <= ATTR_DEFAULT;
      escape_phase <= PH_IDLE;
      digit_count <= 3'd0;
      first_argument <= 7'd0;
      second_argument <= 7'd0;
      stash_row <= 6'd0;
      stash_col <= 7'd0;
    end else if (accept) begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      current_attribute <= current_attribute_next;
      escape_phase <= escape_phase_next;
      digit_count <= digit_count_next;
      first_argument <= first_argument_next;
      second_argument <= second_argument_next;
      stash_row <= stash_row_next;
      stash_col <= stash_col_next;
    end
  end

endmodule
`default_nettype wire

// File: src/ate_queue.sv
// Two-entry queue of command jobs between the parser and the command sequencer.
`default_nettype none
module ate_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ate_pkg::job_t   push_job,
  input  wire logic            pop,
  output      ate_pkg::job_t   head_job,
  output      ate_pkg::q_stat_t q_stat
);
  import ate_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t               entries [QDEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        fill;

  assign head_job = entries[rd_ptr];
  assign q_stat.not_empty = (fill != '0);
  assign q_stat.full = (fill == (PW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) fill <= fill + (PW+1)'(1);
      else if (pop && !push) fill <= fill - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// File: src/ate_back.sv
// Back end: steps through the commands of each job into the output register.
`default_nettype none
module ate_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ate_pkg::job_t    head_job,
  input  wire ate_pkg::q_stat_t q_stat,
  output      logic             pop,
  ate_cmd_if.source             cmds
);
  import ate_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  cmd_t       out_cmd;
  logic       out_last;
  logic       load;
  logic       last;

  assign load = q_stat.not_empty && (!out_valid || cmds.ready);
  assign last = (idx == head_job.count - 2'd1);
  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (cmds.ready) out_valid <= 1'b0;
      if (load) idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd <= head_job.slot[idx];
      out_last <= last;
    end
  end

  assign cmds.valid = out_valid;
  assign cmds.command = out_cmd.command;
  assign cmds.target_row = out_cmd.target_row;
  assign cmds.target_col = out_cmd.target_col;
  assign cmds.char_code = out_cmd.char_code;
  assign cmds.attribute_value = out_cmd.attribute_value;
  assign cmds.source_row = out_cmd.source_row;
  assign cmds.row_count = out_cmd.row_count;
  assign cmds.last_command = out_last;

endmodule
`default_nettype wire

// File: src/ansi_text_console_engine.sv
// Top level of the ANSI text console engine: configuration, parser, job queue, sequencer.
//
//   channel   direction   payload                                   handshake
//   chars     in          char_in[7:0]                              valid/ready
//   cmds      out         command, rows, cols, char, attr, counts   valid/ready
//   cfg       in          cfg_index[0], cfg_data[7:0]               cfg_we
//
// A byte is taken whenever the two-entry job queue has room, so bytes that cause no
// command or a single command flow at one per cycle while the command side is ready.
// The output register sends one command per cycle while cmds.ready is high; a byte
// causing several commands (up to three) holds the output for each of them in turn.
// Reset is synchronous and returns the cursor, parser and screen size to their defaults.
// A stall on the command side fills the queue and then drops ready on the byte side.
`default_nettype none
module ansi_text_console_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  ate_char_if.sink        chars,
  ate_cmd_if.source       cmds,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);
  import ate_pkg::*;

  logic [6:0] screen_rows;
  logic [7:0] screen_cols;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head_job;
  q_stat_t    q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= ROWS_RESET;
      screen_cols <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: screen_rows <= cfg_data[6:0];
        CFG_COLS: screen_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  ate_front u_front (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .screen_rows (screen_rows),
    .screen_cols (screen_cols),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  ate_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  ate_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .cmds     (cmds)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("job pushed into a full queue");

  a_copy_not_last: assert property (@(posedge clk) disable iff (rst)
    (cmds.valid && cmds.command == CMD_COPY) |-> !cmds.last_command)
    else $error("row copy not followed by an erase");

  a_attr_alone: assert property (@(posedge clk) disable iff (rst)
    (cmds.valid && cmds.command == CMD_ATTR) |-> cmds.last_command)
    else $error("attribute command not the only command of its byte");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.not_empty)
    else $error("job queue popped while empty");

endmodule
`default_nettype wire
